// ===== design/rbms_pkg.sv =====
// Package: shared types, codes and reset constants for the roller blind mode sequencer.
`timescale 1ns / 1ps

package rbms_pkg;

  localparam int unsigned OP_W          = 2;
  localparam int unsigned ADDR_W        = 8;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned PARAM_W       = 8;
  localparam int unsigned SW_DELAY_W    = 8;
  localparam int unsigned DELAY_W       = 16;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned MAX_ENTRIES   = 8;
  localparam int unsigned ENT_IDX_W     = 3;
  localparam int unsigned TABLE_ENTRIES_DEF = 8;

  localparam logic [ADDR_W-1:0]     OWN_ADDR_RST       = 8'd1;
  localparam logic [ADDR_W-1:0]     BROADCAST_ADDR_RST = 8'd255;
  localparam logic [SW_DELAY_W-1:0] SWITCH_DELAY_RST   = 8'd10;
  localparam logic [DELAY_W-1:0]    MOVE_LIMIT_RST     = 16'd1000;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_CMD    = 2'd1,
    OP_SWITCH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_STOP    = 2'd0,
    MODE_UP      = 2'd1,
    MODE_DOWN    = 2'd2,
    MODE_UNKNOWN = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_END  = 2'd0,
    ACT_UP   = 2'd1,
    ACT_DOWN = 2'd2,
    ACT_STOP = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_ADDR       = 3'd0,
    REG_BROADCAST_ADDR = 3'd1,
    REG_SWITCH_DELAY   = 3'd2,
    REG_MOVE_LIMIT     = 3'd3,
    REG_TABLE_A        = 3'd4,
    REG_TABLE_B        = 3'd5,
    REG_TABLE_C        = 3'd6,
    REG_TABLE_D        = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [12:0]        rsvd;
    logic               is_switch;
    action_t            action;
    logic [PARAM_W-1:0] param;
    logic [ADDR_W-1:0]  addr;
  } entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0]            own_addr;
    logic [ADDR_W-1:0]            broadcast_addr;
    logic [SW_DELAY_W-1:0]        switch_delay;
    logic [DELAY_W-1:0]           move_limit;
    entry_t [MAX_ENTRIES-1:0]     tbl;
  } cfg_t;

  typedef struct packed {
    logic  hit;
    mode_t mode;
  } match_t;

endpackage

// ===== design/rbms_in_if.sv =====
// Interface: input channel carrying tick, command and switch event transactions.
`timescale 1ns / 1ps

interface rbms_in_if;
  import rbms_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [ADDR_W-1:0]  dest_addr;
  logic [ADDR_W-1:0]  src_addr;
  logic [MODE_W-1:0]  new_mode;
  logic [PARAM_W-1:0] switch_param;

  modport source (output valid, op, dest_addr, src_addr, new_mode, switch_param,
                  input ready);
  modport sink (input valid, op, dest_addr, src_addr, new_mode, switch_param,
                output ready);
endinterface

// ===== design/rbms_out_if.sv =====
// Interface: result channel carrying the new drive mode.
`timescale 1ns / 1ps

interface rbms_out_if;
  import rbms_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] drive_mode;

  modport source (output valid, drive_mode, input ready);
  modport sink (input valid, drive_mode, output ready);
endinterface

// ===== design/roller_blind_mode_sequencer.sv =====
// Top level: roller blind mode sequencer.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------------
//   in_ch    | in  | valid / ready      | op, dest_addr, src_addr, new_mode, switch_param
//   out_ch   | out | valid / ready      | drive_mode
//   cfg_*    | in  | cfg_wr_en          | cfg_index, cfg_wdata
//
// One transaction per cycle while no stalled result holds the input stage: an input stage
// register feeds the table match and state update, and a mode change then lands in the
// result register.
// Synchronous active-low reset; no clearing pass, the block is ready right after reset.
// A stalled result holds the input stage only when that stage would emit another result.
`timescale 1ns / 1ps

module roller_blind_mode_sequencer #(
  parameter int unsigned TABLE_ENTRIES = rbms_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rbms_in_if.sink                         in_ch,
  rbms_out_if.source                      out_ch,
  input  logic                            cfg_wr_en,
  input  logic [rbms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbms_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rbms_pkg::*;

  cfg_t cfg;

  rbms_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rbms_core #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ===== design/rbms_cfg_regs.sv =====
// Configuration register file: addresses, delays and the switch action table.
`timescale 1ns / 1ps

module rbms_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [rbms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbms_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output rbms_pkg::cfg_t                  cfg
);
  import rbms_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_addr       <= OWN_ADDR_RST;
      cfg_r.broadcast_addr <= BROADCAST_ADDR_RST;
      cfg_r.switch_delay   <= SWITCH_DELAY_RST;
      cfg_r.move_limit     <= MOVE_LIMIT_RST;
      cfg_r.tbl            <= '0;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_OWN_ADDR:       cfg_r.own_addr       <= cfg_wdata[ADDR_W-1:0];
        REG_BROADCAST_ADDR: cfg_r.broadcast_addr <= cfg_wdata[ADDR_W-1:0];
        REG_SWITCH_DELAY:   cfg_r.switch_delay   <= cfg_wdata[SW_DELAY_W-1:0];
        REG_MOVE_LIMIT:     cfg_r.move_limit     <= cfg_wdata[DELAY_W-1:0];
        REG_TABLE_A:        cfg_r.tbl[1:0]       <= cfg_wdata;
        REG_TABLE_B:        cfg_r.tbl[3:2]       <= cfg_wdata;
        REG_TABLE_C:        cfg_r.tbl[5:4]       <= cfg_wdata;
        REG_TABLE_D:        cfg_r.tbl[7:6]       <= cfg_wdata;
        default:            cfg_r.own_addr       <= cfg_r.own_addr;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/rbms_table_match.sv =====
// Switch action table match: first matching switch entry before the end marker.
`timescale 1ns / 1ps

module rbms_table_match #(
  parameter int unsigned TABLE_ENTRIES = rbms_pkg::TABLE_ENTRIES_DEF
) (
  input  rbms_pkg::entry_t [rbms_pkg::MAX_ENTRIES-1:0] tbl,
  input  logic [rbms_pkg::ADDR_W-1:0]                  broadcast_addr,
  input  logic [rbms_pkg::ADDR_W-1:0]                  src_addr,
  input  logic [rbms_pkg::PARAM_W-1:0]                 switch_param,
  output rbms_pkg::match_t                             match
);
  import rbms_pkg::*;

  always_comb begin
    logic   ended;
    entry_t e;
    ended      = 1'b0;
    match.hit  = 1'b0;
    match.mode = MODE_STOP;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      e = tbl[k[ENT_IDX_W-1:0]];
      if (!ended && !match.hit) begin
        if (e.action == ACT_END) begin
          ended = 1'b1;
        end else if (e.is_switch && (e.addr == src_addr || e.addr == broadcast_addr)
                     && e.param == switch_param) begin
          match.hit = 1'b1;
          unique case (e.action)
            ACT_UP:   match.mode = MODE_UP;
            ACT_DOWN: match.mode = MODE_DOWN;
            default:  match.mode = MODE_STOP;
          endcase
        end
      end
    end
  end

endmodule

// ===== design/rbms_core.sv =====
// Sequencer core: input stage, mode and delay state, result register.
`timescale 1ns / 1ps

module rbms_core #(
  parameter int unsigned TABLE_ENTRIES = rbms_pkg::TABLE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rbms_pkg::cfg_t cfg,
  rbms_in_if.sink        in_ch,
  rbms_out_if.source     out_ch
);
  import rbms_pkg::*;

  logic               s1_v_r;
  op_t                s1_op_r;
  logic [ADDR_W-1:0]  s1_dest_r;
  logic [ADDR_W-1:0]  s1_src_r;
  logic [MODE_W-1:0]  s1_mode_r;
  logic [PARAM_W-1:0] s1_param_r;

  mode_t              cur_r, cur_nxt;
  mode_t              tgt_r, tgt_nxt;
  logic [DELAY_W-1:0] dly_r, dly_nxt;

  logic               out_v_r;
  mode_t              out_mode_r;

  match_t             match;
  logic               emit;
  logic               out_free;
  logic               go;
  logic [DELAY_W-1:0] sw_delay_ext;

  rbms_table_match #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_match (
    .tbl            (cfg.tbl),
    .broadcast_addr (cfg.broadcast_addr),
    .src_addr       (s1_src_r),
    .switch_param   (s1_param_r),
    .match          (match)
  );

  assign sw_delay_ext = {{(DELAY_W-SW_DELAY_W){1'b0}}, cfg.switch_delay};
  assign emit     = s1_v_r && s1_op_r == OP_TICK && cur_r != tgt_r && dly_r == '0;
  assign out_free = !out_v_r || out_ch.ready;
  assign go       = s1_v_r && (!emit || out_free);
  assign in_ch.ready = !s1_v_r || go;

  always_comb begin
    cur_nxt = cur_r;
    tgt_nxt = tgt_r;
    dly_nxt = dly_r;
    unique case (s1_op_r)
      OP_CMD: begin
        if (s1_dest_r == cfg.own_addr) begin
          tgt_nxt = (mode_t'(s1_mode_r) == MODE_UNKNOWN) ? MODE_STOP : mode_t'(s1_mode_r);
          dly_nxt = sw_delay_ext;
        end
      end
      OP_SWITCH: begin
        if (match.hit) begin
          tgt_nxt = match.mode;
          dly_nxt = sw_delay_ext;
        end
      end
      OP_TICK: begin
        if (cur_r != tgt_r) begin
          if (dly_r != '0) begin
            dly_nxt = dly_r - 1'b1;
          end else if (cur_r == MODE_STOP) begin
            cur_nxt = tgt_r;
            tgt_nxt = MODE_STOP;
            dly_nxt = cfg.move_limit;
          end else begin
            cur_nxt = MODE_STOP;
            dly_nxt = sw_delay_ext;
          end
        end
      end
      default: cur_nxt = cur_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      cur_r   <= MODE_UNKNOWN;
      tgt_r   <= MODE_STOP;
      dly_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (go) begin
        cur_r <= cur_nxt;
        tgt_r <= tgt_nxt;
        dly_r <= dly_nxt;
      end
      if (go && emit) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r    <= op_t'(in_ch.op);
      s1_dest_r  <= in_ch.dest_addr;
      s1_src_r   <= in_ch.src_addr;
      s1_mode_r  <= in_ch.new_mode;
      s1_param_r <= in_ch.switch_param;
    end
    if (go && emit) begin
      out_mode_r <= cur_nxt;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.drive_mode = out_mode_r;

endmodule
